// ----- rtl/bgc_pkg.sv -----
// Shared types and constants for the button gesture classifier.
package bgc_pkg;

    localparam int LEVEL_W     = 7;
    localparam int INDEX_W     = 3;
    localparam int TICK_W      = 32;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int LPT_W       = 16;
    localparam int ACTIVE_W    = 3;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_BUTTONS   = 1'd1;

    localparam logic [LPT_W-1:0]    LONG_PRESS_RESET = 16'd1000;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RESET     = 3'd7;

    typedef enum logic [1:0] {
        KIND_DOWN         = 2'd0,
        KIND_SHORT        = 2'd1,
        KIND_LONG_RELEASE = 2'd2,
        KIND_LONG_PRESS   = 2'd3
    } kind_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] debounced_levels;
        logic [LEVEL_W-1:0] raw_levels;
    } in_item_t;

    typedef struct packed {
        kind_t              event_kind;
        logic [INDEX_W-1:0] button_index;
        logic [LEVEL_W-1:0] raw_mask;
        logic               last_event;
    } out_item_t;

endpackage

// ----- rtl/bgc_front.sv -----
// Front end: takes ticks, holds config, per-button state, classifies events.
module bgc_front #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  bgc_pkg::in_item_t                in_data,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             queue_full,
    output logic                             push,
    output logic [NUM_BUTTONS-1:0]           ev_mask,
    output logic [2*NUM_BUTTONS-1:0]         ev_kind,
    output logic [bgc_pkg::LEVEL_W-1:0]      ev_raw
);
    import bgc_pkg::*;

    localparam int CNT_W = $clog2(NUM_BUTTONS + 1);
    localparam int PAD_W = (NUM_BUTTONS > LEVEL_W) ? NUM_BUTTONS : LEVEL_W;

    logic [LPT_W-1:0]       lpt_reg;
    logic [ACTIVE_W-1:0]    active_reg;
    logic [TICK_W-1:0]      tick_reg;
    logic [NUM_BUTTONS-1:0] prev_reg;
    logic [NUM_BUTTONS-1:0] prev_next;
    logic [TICK_W-1:0]      stamp_reg  [NUM_BUTTONS];
    logic [TICK_W-1:0]      stamp_next [NUM_BUTTONS];
    logic [TICK_W-1:0]      held       [NUM_BUTTONS];

    logic [TICK_W-1:0]      now;
    logic [TICK_W-1:0]      lpt;
    logic [CNT_W-1:0]       count;
    logic [PAD_W-1:0]       pad;
    logic [NUM_BUTTONS-1:0] levels;
    logic                   accept;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && (ev_mask != '0);
    assign ev_raw    = in_data.raw_levels;

    always_comb
    begin
        now    = tick_reg + TICK_W'(1);
        lpt    = TICK_W'(lpt_reg);
        pad    = PAD_W'(in_data.debounced_levels);
        levels = pad[NUM_BUTTONS-1:0];
        if (32'(active_reg) > NUM_BUTTONS)
            count = CNT_W'(NUM_BUTTONS);
        else
            count = CNT_W'(active_reg);
        prev_next = prev_reg;
        ev_mask   = '0;
        ev_kind   = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            held[i]       = now - stamp_reg[i];
            stamp_next[i] = stamp_reg[i];
            if (CNT_W'(i) < count)
            begin
                prev_next[i] = levels[i];
                if (levels[i] && !prev_reg[i])
                begin
                    ev_mask[i]          = 1'b1;
                    ev_kind[2*i +: 2]   = KIND_DOWN;
                    stamp_next[i]       = now;
                end
                else if (!levels[i] && prev_reg[i])
                begin
                    ev_mask[i]        = 1'b1;
                    ev_kind[2*i +: 2] = (held[i] < lpt) ? KIND_SHORT : KIND_LONG_RELEASE;
                    stamp_next[i]     = '0;
                end
                else if (levels[i] && (held[i] == lpt))
                begin
                    ev_mask[i]        = 1'b1;
                    ev_kind[2*i +: 2] = KIND_LONG_PRESS;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpt_reg    <= LONG_PRESS_RESET;
            active_reg <= ACTIVE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_LONG_PRESS_TICKS: lpt_reg    <= cfg_data[LPT_W-1:0];
                REG_ACTIVE_BUTTONS:   active_reg <= cfg_data[ACTIVE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg <= '0;
            prev_reg <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++)
                stamp_reg[i] <= '0;
        end
        else if (accept)
        begin
            tick_reg <= now;
            prev_reg <= prev_next;
            for (int i = 0; i < NUM_BUTTONS; i++)
                stamp_reg[i] <= stamp_next[i];
        end
    end

endmodule

// ----- rtl/bgc_fifo.sv -----
// Small register queue between the classifier and the event drain.
module bgc_fifo #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             nonempty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign rdata    = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ----- rtl/bgc_back.sv -----
// Back end: emits a queued tick's events, lowest first, one per unstalled cycle.
module bgc_back #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         head_valid,
    input  logic [NUM_BUTTONS-1:0]       head_mask,
    input  logic [2*NUM_BUTTONS-1:0]     head_kind,
    input  logic [bgc_pkg::LEVEL_W-1:0]  head_raw,
    output logic                         pop,
    output logic                         out_valid,
    input  logic                         out_stall,
    output bgc_pkg::out_item_t           out_data
);
    import bgc_pkg::*;

    localparam int IDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [NUM_BUTTONS-1:0] done_reg, done_next;
    logic                   out_valid_reg, out_valid_next;
    out_item_t              out_reg, out_next;

    logic [NUM_BUTTONS-1:0] rem;
    logic [NUM_BUTTONS-1:0] pick;
    logic [IDX_W-1:0]       idx;
    logic [1:0]             kind;
    logic                   last;
    logic                   advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        rem     = head_mask & ~done_reg;
        pick    = rem & (~rem + NUM_BUTTONS'(1));
        last    = ((rem & ~pick) == '0);
        advance = head_valid && (!out_valid_reg || !out_stall);
        idx     = '0;
        kind    = '0;
        for (int i = 0; i < NUM_BUTTONS; i++)
        begin
            if (pick[i])
            begin
                idx  = IDX_W'(i);
                kind = head_kind[2*i +: 2];
            end
        end

        pop            = advance && last;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next        = 1'b1;
            out_next.event_kind   = kind_t'(kind);
            out_next.button_index = INDEX_W'(idx);
            out_next.raw_mask     = head_raw;
            out_next.last_event   = last;
            done_next             = last ? '0 : (done_reg | pick);
        end
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            done_reg      <= done_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

endmodule

// ----- rtl/button_gesture_classifier.sv -----
// Top level of the button gesture classifier: front end, event queue, drain.
//
//  channel | direction | handshake            | beat contents
//  --------+-----------+----------------------+-------------------------------------------
//  in      | to block  | in_valid / in_stall  | debounced_levels, raw_levels (one tick)
//  out     | from block| out_valid / out_stall| event_kind, button_index, raw_mask, last_event
//  cfg     | to block  | cfg_valid / cfg_ready| cfg_index, cfg_data (register write)
//
// The front end takes a tick beat every cycle while the queue has room and
// classifies all scanned buttons of that tick at once. The drain emits one
// event per cycle while out_stall is low, so a tick with k events yields k
// output beats (at most NUM_BUTTONS); a tick with no events is not queued.
// Reset is asynchronous and clears control state at once (not the queue or
// output data storage): no clearing pass. An output stall holds the output
// register; the queue absorbs ticks until it fills, then in_stall rises.
module button_gesture_classifier #(
    parameter int NUM_BUTTONS = 7
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  bgc_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output bgc_pkg::out_item_t              out_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bgc_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import bgc_pkg::*;

    localparam int ENTRY_W = 3 * NUM_BUTTONS + LEVEL_W;

    // Queue entry: event mask, two-bit kinds per button, raw mask.
    logic                     push;
    logic                     pop;
    logic                     queue_full;
    logic                     queue_nonempty;
    logic [NUM_BUTTONS-1:0]   ev_mask;
    logic [2*NUM_BUTTONS-1:0] ev_kind;
    logic [LEVEL_W-1:0]       ev_raw;
    logic [ENTRY_W-1:0]       head;

    bgc_front #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .queue_full (queue_full),
        .push       (push),
        .ev_mask    (ev_mask),
        .ev_kind    (ev_kind),
        .ev_raw     (ev_raw)
    );

    // Hold classified ticks so input and output can stall independently.
    bgc_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wdata    ({ev_mask, ev_kind, ev_raw}),
        .pop      (pop),
        .rdata    (head),
        .full     (queue_full),
        .nonempty (queue_nonempty)
    );

    bgc_back #(
        .NUM_BUTTONS (NUM_BUTTONS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (queue_nonempty),
        .head_mask  (head[ENTRY_W-1 -: NUM_BUTTONS]),
        .head_kind  (head[LEVEL_W +: 2*NUM_BUTTONS]),
        .head_raw   (head[LEVEL_W-1:0]),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // A tick with events only enters when the queue has room.
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("tick pushed into a full queue");

    // The drain only retires a queue entry that exists.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> queue_nonempty)
        else $error("queue popped while empty");

    // Retiring an entry always presents that tick's last event next.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid && out_data.last_event))
        else $error("entry retired without a marked last event");

    // Events never name a button outside the scanned range.
    a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(out_data.button_index) < NUM_BUTTONS))
        else $error("event for a button that does not exist");

endmodule
